[rtl/assert_macros.svh]
// assertion macros of the valve controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define VPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define VPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/vpc_pkg.sv]
// shared constants, register codes and stage types of the valve pi controller
package vpc_pkg;

  localparam int TEMP_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int ANGLE_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // gain x error products signed q14.20, their sum signed q16.20
  localparam int PROD_W   = GAIN_W + TEMP_W + 2;
  localparam int ACC_W    = PROD_W + 2;
  localparam int FRAC_SH  = 12;
  localparam int QUOT_W   = ACC_W - FRAC_SH;

  localparam logic [ANGLE_W-1:0] ANGLE_CEIL = 15'd23040;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SETPOINT    = 3'd0;
  localparam cfg_idx_t CFG_PROP_GAIN   = 3'd1;
  localparam cfg_idx_t CFG_INTEG_GAIN  = 3'd2;
  localparam cfg_idx_t CFG_DERIV_GAIN  = 3'd3;
  localparam cfg_idx_t CFG_INTEG_LIMIT = 3'd4;
  localparam cfg_idx_t CFG_OUT_MAX     = 3'd5;
  localparam cfg_idx_t CFG_MARGIN      = 3'd6;

  localparam logic [TEMP_W-1:0] SETPOINT_RST    = 16'd0;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd8192;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 16'd410;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 16'd0;
  localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST = 15'd10240;
  localparam logic [LIM_W-1:0]  OUT_MAX_RST     = 15'd23040;
  localparam logic [LIM_W-1:0]  MARGIN_RST      = 15'd128;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint;
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic [LIM_W-1:0]         integ_limit;
    logic [ANGLE_W-1:0]       out_max;
    logic [LIM_W-1:0]         margin;
  } cfg_t;

  // error stage result handed to the multiply stage
  typedef struct packed {
    logic signed [TEMP_W-1:0] err;
    logic signed [TEMP_W:0]   diff;
    logic signed [TEMP_W-1:0] isum;
    logic                     upd;
  } err_data_t;

endpackage

[rtl/vpc_sample_if.sv]
// request channel carrying one measured temperature sample
interface vpc_sample_if;
  logic                             valid;
  logic                             ready;
  logic signed [vpc_pkg::TEMP_W-1:0] measured_temp;

  modport source (output valid, output measured_temp, input ready);
  modport sink   (input valid, input measured_temp, output ready);
endinterface

[rtl/vpc_result_if.sv]
// request channel carrying one drive command result
interface vpc_result_if;
  logic                              valid;
  logic                              ready;
  logic [vpc_pkg::ANGLE_W-1:0]       drive_angle;
  logic                              drive_update;
  logic signed [vpc_pkg::TEMP_W-1:0] temp_error;

  modport source (output valid, output drive_angle, output drive_update, output temp_error,
                  input ready);
  modport sink   (input valid, input drive_angle, input drive_update, input temp_error,
                  output ready);
endinterface

[rtl/vpc_cfg_if.sv]
// configuration write channel: register index and write data
interface vpc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vpc_pkg::CFG_IDX_W-1:0]     index;
  logic [vpc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/vpc_cfg_regs.sv]
// configuration register file of the valve pi controller
module vpc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  vpc_cfg_if.sink       cfg,
  output vpc_pkg::cfg_t regs
);
  import vpc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.setpoint    <= SETPOINT_RST;
      regs.prop_gain   <= PROP_GAIN_RST;
      regs.integ_gain  <= INTEG_GAIN_RST;
      regs.deriv_gain  <= DERIV_GAIN_RST;
      regs.integ_limit <= INTEG_LIMIT_RST;
      regs.out_max     <= OUT_MAX_RST;
      regs.margin      <= MARGIN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SETPOINT:    regs.setpoint    <= cfg.data;
        CFG_PROP_GAIN:   regs.prop_gain   <= cfg.data;
        CFG_INTEG_GAIN:  regs.integ_gain  <= cfg.data;
        CFG_DERIV_GAIN:  regs.deriv_gain  <= cfg.data;
        CFG_INTEG_LIMIT: regs.integ_limit <= cfg.data[LIM_W-1:0];
        CFG_OUT_MAX:     regs.out_max     <= cfg.data[ANGLE_W-1:0];
        CFG_MARGIN:      regs.margin      <= cfg.data[LIM_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

[rtl/vpc_err_stage.sv]
// error stage: saturated error, derivative difference, integrator and previous error
module vpc_err_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  vpc_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  input  logic signed [vpc_pkg::TEMP_W-1:0] in_meas,
  output logic                             in_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output vpc_pkg::err_data_t               out_data
);
  import vpc_pkg::*;

  logic signed [TEMP_W-1:0] integ_sum;
  logic signed [TEMP_W-1:0] prev_error;

  logic signed [TEMP_W:0]   raw_err;
  logic signed [TEMP_W-1:0] err;
  logic signed [TEMP_W:0]   diff;
  logic signed [TEMP_W:0]   isum_add;
  logic signed [TEMP_W:0]   lim_pos;
  logic signed [TEMP_W:0]   lim_neg;
  logic signed [TEMP_W-1:0] integ_sum_next;
  logic [TEMP_W:0]          mag;
  logic                     load;

  assign raw_err = {cfg.setpoint[TEMP_W-1], cfg.setpoint} - {in_meas[TEMP_W-1], in_meas};

  // saturate when the two top bits disagree
  assign err = (raw_err[TEMP_W] ^ raw_err[TEMP_W-1])
             ? {raw_err[TEMP_W], {(TEMP_W-1){~raw_err[TEMP_W]}}}
             : raw_err[TEMP_W-1:0];

  assign diff     = {prev_error[TEMP_W-1], prev_error} - {err[TEMP_W-1], err};
  assign isum_add = {integ_sum[TEMP_W-1], integ_sum} + {err[TEMP_W-1], err};
  assign lim_pos  = {2'b00, cfg.integ_limit};
  assign lim_neg  = -lim_pos;

  always_comb begin
    priority if (isum_add > lim_pos) begin
      integ_sum_next = lim_pos[TEMP_W-1:0];
    end else if (isum_add < lim_neg) begin
      integ_sum_next = lim_neg[TEMP_W-1:0];
    end else begin
      integ_sum_next = isum_add[TEMP_W-1:0];
    end
  end

  // full-scale negative error gives 32768, still exact in 17 bits
  assign mag = err[TEMP_W-1] ? (TEMP_W+1)'(-$signed({err[TEMP_W-1], err}))
                             : {1'b0, err};

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      integ_sum  <= '0;
      prev_error <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load) begin
        integ_sum  <= integ_sum_next;
        prev_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.err  <= err;
      out_data.diff <= diff;
      out_data.isum <= integ_sum;
      out_data.upd  <= (mag > {2'b00, cfg.margin});
    end
  end

endmodule

[rtl/vpc_out_stage.sv]
// multiply stage and sum, clamp and result register
module vpc_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  vpc_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  vpc_pkg::err_data_t in_data,
  output logic               in_ready,
  vpc_result_if.source       result
);
  import vpc_pkg::*;

  // product stage registers
  logic                     p_valid;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [TEMP_W-1:0] p_err;
  logic                     p_upd;

  // result registers
  logic                     r_valid;
  logic [ANGLE_W-1:0]       r_angle;
  logic                     r_upd;
  logic signed [TEMP_W-1:0] r_err;

  logic                     r_ready;
  logic                     p_ready;
  logic signed [TEMP_W+GAIN_W:0] mul_p;
  logic signed [TEMP_W+GAIN_W:0] mul_i;
  logic signed [PROD_W-1:0]      mul_d;
  logic signed [ACC_W-1:0]  acc;
  logic [QUOT_W-1:0]        quot;
  logic [ANGLE_W-1:0]       cap;
  logic [ANGLE_W-1:0]       angle;

  // gains are unsigned, operands widened to the full product width
  assign mul_p = $signed({{(TEMP_W+1){1'b0}}, cfg.prop_gain})
               * (TEMP_W+GAIN_W+1)'(in_data.err);
  assign mul_i = $signed({{(TEMP_W+1){1'b0}}, cfg.integ_gain})
               * (TEMP_W+GAIN_W+1)'(in_data.isum);
  assign mul_d = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.deriv_gain})
               * PROD_W'(in_data.diff);

  assign r_ready  = !r_valid || result.ready;
  assign p_ready  = !p_valid || r_ready;
  assign in_ready = p_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && in_valid) begin
      prod_p <= PROD_W'(mul_p);
      prod_i <= PROD_W'(mul_i);
      prod_d <= mul_d;
      p_err  <= in_data.err;
      p_upd  <= in_data.upd;
    end
  end

  assign acc  = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
  assign quot = acc[ACC_W-1:FRAC_SH];
  assign cap  = (cfg.out_max > ANGLE_CEIL) ? ANGLE_CEIL : cfg.out_max;

  always_comb begin
    priority if (acc[ACC_W-1] || (acc == '0)) begin
      angle = '0;
    end else if (quot > QUOT_W'(cap)) begin
      angle = cap;
    end else begin
      angle = quot[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (r_ready) begin
      r_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_ready && p_valid) begin
      r_angle <= angle;
      r_upd   <= p_upd;
      r_err   <= p_err;
    end
  end

  assign result.valid        = r_valid;
  assign result.drive_angle  = r_angle;
  assign result.drive_update = r_upd;
  assign result.temp_error   = r_err;

endmodule

[rtl/valve_pi_controller.sv]
// top level of the valve pi controller: sample register, error, multiply and result stages
//
// usage
// - sample: one request per measured inlet temperature (signed q8.8), taken on
//   valid and ready high at a rising edge of clk
// - result: one request per sample, in order: drive angle (unsigned q7.8, 0..min(out_max,
//   23040)), update flag (|error| above margin) and the saturated error
// - cfg: register writes by index (setpoint, three gains, integrator limit,
//   angle clamp, margin); always ready, meant for use while no sample is in flight
// - a taken sample passes the sample register, error stage, product register and
//   result register in that order before it shows up on the result channel
// - throughput: one sample per cycle while results are taken; the integrator and
//   previous error update in the error stage, so no sample waits on the one before it
// - a stalled result holds its register, the stages behind it fill, and sample
//   ready drops only once all four registers are occupied
// - reset (rst, synchronous) empties the pipeline, zeroes integrator and previous
//   error and loads the register defaults
`include "assert_macros.svh"

module valve_pi_controller (
  input  logic          clk,
  input  logic          rst,
  vpc_sample_if.sink    sample,
  vpc_result_if.source  result,
  vpc_cfg_if.sink       cfg
);
  import vpc_pkg::*;

  cfg_t                     regs;

  // sample register
  logic                     in_vld;
  logic signed [TEMP_W-1:0] in_meas;

  // error stage to multiply stage
  logic                     e_ready;
  logic                     e_valid;
  logic                     m_ready;
  err_data_t                e_data;

  vpc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // sample register moves on whenever the error stage takes its content
  assign sample.ready = !in_vld || e_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (sample.ready) begin
      in_vld <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      in_meas <= sample.measured_temp;
    end
  end

  // error, integrator clamp and previous error
  vpc_err_stage u_err (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .in_valid  (in_vld),
    .in_meas   (in_meas),
    .in_ready  (e_ready),
    .out_valid (e_valid),
    .out_ready (m_ready),
    .out_data  (e_data)
  );

  // three gain products, sum to q8.8 and angle clamp
  vpc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .cfg      (regs),
    .in_valid (e_valid),
    .in_data  (e_data),
    .in_ready (m_ready),
    .result   (result)
  );

  // pipeline is empty right after reset
  `VPC_ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !result.valid && !in_vld, "result valid after reset")
  // a taken sample always lands in the sample register
  `VPC_ASSERT(a_sample_load, sample.valid && sample.ready |=> in_vld, "sample request lost")
  // drive angle never leaves the valve range
  `VPC_ASSERT(a_angle_range, result.valid |-> result.drive_angle <= ANGLE_CEIL, "angle out of range")
  // an update needs a nonzero error
  `VPC_ASSERT(a_update_err, result.valid && result.drive_update |-> result.temp_error != '0,
              "update flag with zero error")

endmodule
